// ===== rtl/core/sat_pkg.sv =====
// Shared types and constants for the shared access tracker.
// No dependencies; imported by every module of the block.
package sat_pkg;

    localparam int ADDR_FIELD_W   = 16;
    localparam int THREAD_FIELD_W = 8;
    localparam int INST_FIELD_W   = 12;
    localparam int COUNT_FIELD_W  = 32;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [ADDR_FIELD_W-1:0]   address;
        logic [THREAD_FIELD_W-1:0] thread_id;
        logic [INST_FIELD_W-1:0]   inst_index;
    } sat_in_t;

    typedef struct packed {
        logic [COUNT_FIELD_W-1:0] access_count;
        logic                     is_shared;
        logic                     inst_logged;
        logic                     inst_newly_logged;
        logic [ADDR_FIELD_W-1:0]  lowest_address;
        logic [ADDR_FIELD_W-1:0]  highest_address;
    } sat_out_t;

endpackage

// ===== rtl/core/sat_front.sv =====
// Front end: accepts input transactions, masks fields, checks the
// instruction range and tracks the address range. Depends on sat_pkg.
module sat_front
    import sat_pkg::*;
#(
    parameter int ADDR_BITS   = 16,
    parameter int THREAD_BITS = 8,
    parameter int INST_COUNT  = 4096,
    parameter int INST_BITS   = 12,
    parameter int ITEM_W      = 3 * 16 + 8 + 1 + 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sat_in_t           s_data,
    input  logic              clear_done,
    input  logic              q_full,
    output logic              q_push,
    output logic [ITEM_W-1:0] q_data
);

    typedef struct packed {
        logic [ADDR_BITS-1:0]   addr;
        logic [THREAD_BITS-1:0] tid;
        logic                   inst_ok;
        logic [INST_BITS-1:0]   inst_sel;
        logic [ADDR_BITS-1:0]   lo;
        logic [ADDR_BITS-1:0]   hi;
    } item_t;

    logic [ADDR_BITS-1:0] min_reg, min_next;
    logic [ADDR_BITS-1:0] max_reg, max_next;
    logic [31:0]          addr_ext;
    logic [15:0]          tid_ext;
    logic [31:0]          inst_ext;
    logic [ADDR_BITS-1:0] addr;
    item_t                item;

    assign s_ready  = clear_done && !q_full;
    assign q_push   = s_valid && s_ready;

    assign addr_ext = 32'(s_data.address);
    assign tid_ext  = 16'(s_data.thread_id);
    assign inst_ext = 32'(s_data.inst_index);
    assign addr     = addr_ext[ADDR_BITS-1:0];

    assign min_next = (addr < min_reg) ? addr : min_reg;
    assign max_next = (addr > max_reg) ? addr : max_reg;

    always_comb begin
        item.addr     = addr;
        item.tid      = tid_ext[THREAD_BITS-1:0];
        item.inst_ok  = inst_ext < 32'(INST_COUNT);
        item.inst_sel = inst_ext[INST_BITS-1:0];
        item.lo       = min_next;
        item.hi       = max_next;
    end

    assign q_data = item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= '1;
            max_reg <= '0;
        end else if (q_push) begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

endmodule

// ===== rtl/core/sat_queue.sv =====
// Short FIFO between the front end and the back end.
// Depends on sat_pkg for its depth.
module sat_queue
    import sat_pkg::*;
#(
    parameter int WIDTH = 69
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full      = cnt_reg == CNT_W'(QUEUE_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/sat_back.sv =====
// Back end: clears the tables after reset, then does the per-address
// read-modify-write and the bitmap update, and holds the result register.
// Depends on sat_pkg.
module sat_back
    import sat_pkg::*;
#(
    parameter int ADDR_BITS   = 16,
    parameter int THREAD_BITS = 8,
    parameter int INST_COUNT  = 4096,
    parameter int INST_BITS   = 12,
    parameter int COUNT_BITS  = 32,
    parameter int ITEM_W      = 3 * 16 + 8 + 1 + 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  logic [ITEM_W-1:0] q_data,
    output logic              q_pop,
    output logic              clear_done,
    output logic              m_valid,
    input  logic              m_ready,
    output sat_out_t          m_data
);

    localparam int CLR_BITS = (ADDR_BITS > INST_BITS) ? ADDR_BITS : INST_BITS;
    localparam longint unsigned TBL_DEPTH = 64'd1 << ADDR_BITS;

    typedef struct packed {
        logic [ADDR_BITS-1:0]   addr;
        logic [THREAD_BITS-1:0] tid;
        logic                   inst_ok;
        logic [INST_BITS-1:0]   inst_sel;
        logic [ADDR_BITS-1:0]   lo;
        logic [ADDR_BITS-1:0]   hi;
    } item_t;

    typedef struct packed {
        logic                   touched;
        logic                   shared;
        logic [THREAD_BITS-1:0] last;
        logic [COUNT_BITS-1:0]  count;
    } entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    entry_t            tbl_mem [TBL_DEPTH];
    logic              bm_mem  [INST_COUNT];

    state_t            state_reg;
    logic [CLR_BITS-1:0] clr_reg;
    item_t             work_reg;
    entry_t            tbl_rd_reg;
    logic              bm_rd_reg;
    logic              out_valid_reg;
    sat_out_t          out_reg;

    item_t             head;
    logic              slot_free;
    logic              exec_fire;
    logic              touched;
    logic              new_thread;
    logic              shared_new;
    logic [COUNT_BITS-1:0] count_old;
    logic [COUNT_BITS-1:0] count_new;
    logic              logged;
    logic              newly;
    entry_t            wr_entry;
    logic [63:0]       count_ext;
    logic [31:0]       lo_ext;
    logic [31:0]       hi_ext;

    assign head       = q_data;
    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign clear_done = state_reg != ST_CLEAR;
    assign slot_free  = !out_valid_reg || m_ready;
    assign exec_fire  = (state_reg == ST_EXEC) && slot_free;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;

    // untouched entries read back all zero after the clearing pass
    always_comb begin
        touched    = tbl_rd_reg.touched;
        new_thread = !touched || (tbl_rd_reg.last != work_reg.tid);
        shared_new = tbl_rd_reg.shared || (touched && new_thread);
        count_old  = touched ? tbl_rd_reg.count : '0;
        count_new  = (&count_old) ? count_old : count_old + 1'b1;
        logged     = (shared_new || new_thread) && work_reg.inst_ok;
        newly      = logged && !bm_rd_reg;
        wr_entry.touched = 1'b1;
        wr_entry.shared  = shared_new;
        wr_entry.last    = work_reg.tid;
        wr_entry.count   = count_new;
        count_ext  = 64'(count_new);
        lo_ext     = 32'(work_reg.lo);
        hi_ext     = 32'(work_reg.hi);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_ready && !exec_fire) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (slot_free) begin
                        out_valid_reg             <= 1'b1;
                        out_reg.access_count      <= count_ext[31:0];
                        out_reg.is_shared         <= shared_new;
                        out_reg.inst_logged       <= logged;
                        out_reg.inst_newly_logged <= newly;
                        out_reg.lowest_address    <= lo_ext[15:0];
                        out_reg.highest_address   <= hi_ext[15:0];
                        state_reg                 <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            work_reg   <= head;
            tbl_rd_reg <= tbl_mem[head.addr];
            bm_rd_reg  <= bm_mem[head.inst_sel];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            tbl_mem[clr_reg[ADDR_BITS-1:0]] <= '0;
        end else if (exec_fire) begin
            tbl_mem[work_reg.addr] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            bm_mem[clr_reg[INST_BITS-1:0]] <= 1'b0;
        end else if (exec_fire && logged) begin
            bm_mem[work_reg.inst_sel] <= 1'b1;
        end
    end

endmodule

// ===== rtl/core/shared_access_tracker_top.sv =====
// Shared access tracker: per-address sharing detection and instruction log.
// Top level; instantiates sat_front, sat_queue and sat_back. Uses sat_pkg.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one memory access per
//   transaction (address, thread_id, inst_index). Output channel
//   m_valid/m_ready/m_data returns exactly one result per access, in order.
//   The front end pushes each transaction into a two-entry queue; the
//   back end pops it, reads the address table and the instruction bitmap,
//   then writes them back when the output register is free to take the
//   result, and it pops no new access until that write-back is done.
//   Reset (aresetn low, synchronous) starts a clearing pass that zeroes
//   the table and the bitmap one entry per cycle; s_ready stays low until
//   it finishes.
//   When the receiver stalls, the result waits in the output register and
//   the queue keeps taking transactions until it is full.
module shared_access_tracker_top
    import sat_pkg::*;
#(
    parameter int ADDR_BITS   = 16,
    parameter int THREAD_BITS = 8,
    parameter int INST_COUNT  = 4096,
    parameter int COUNT_BITS  = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sat_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sat_out_t m_data
);

    localparam int INST_BITS = $clog2(INST_COUNT);
    localparam int ITEM_W    = 3 * ADDR_BITS + THREAD_BITS + 1 + INST_BITS;

    logic              clear_done;
    logic              q_full;
    logic              q_push;
    logic [ITEM_W-1:0] q_push_data;
    logic              q_pop;
    logic              q_valid;
    logic [ITEM_W-1:0] q_head;

    sat_front #(
        .ADDR_BITS   (ADDR_BITS),
        .THREAD_BITS (THREAD_BITS),
        .INST_COUNT  (INST_COUNT),
        .INST_BITS   (INST_BITS),
        .ITEM_W      (ITEM_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .clear_done (clear_done),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_push_data)
    );

    sat_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_data (q_head)
    );

    sat_back #(
        .ADDR_BITS   (ADDR_BITS),
        .THREAD_BITS (THREAD_BITS),
        .INST_COUNT  (INST_COUNT),
        .INST_BITS   (INST_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .ITEM_W      (ITEM_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_data     (q_head),
        .q_pop      (q_pop),
        .clear_done (clear_done),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== tb/sv/shared_access_tracker_top_tb.sv =====
// Self-checking testbench for shared_access_tracker_top: directed and random access
// traces against a behavioral model of the address table and instruction bitmap.
// Depends on sat_pkg and the RTL under rtl/core.
module shared_access_tracker_top_tb;
    import sat_pkg::*;

    localparam int TABLE_SIZE  = 2 ** ADDR_FIELD_W;
    localparam int INST_SIZE   = 2 ** INST_FIELD_W;
    localparam int N_RANDOM    = 1000;
    localparam int QUIET_ITEMS = 150;     // no idling once this few remain
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;  // also covers the clearing pass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sat_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sat_out_t m_data;

    sat_in_t  accesses_pending[$];
    sat_out_t results_due[$];

    int errors     = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_shared   = 0;
    int n_fresh    = 0;
    int cycles     = 0;
    int idle_left  = 0;
    int stall_left = 0;

    // shadow of the tracker state
    bit                      touched_tbl [TABLE_SIZE];
    bit [THREAD_FIELD_W-1:0] thread_tbl  [TABLE_SIZE];
    bit                      shared_tbl  [TABLE_SIZE];
    bit [COUNT_FIELD_W-1:0]  count_tbl   [TABLE_SIZE];
    bit                      inst_map    [INST_SIZE];
    bit [ADDR_FIELD_W-1:0]   low_seen  = '1;
    bit [ADDR_FIELD_W-1:0]   high_seen = '0;

    shared_access_tracker_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic sat_out_t track_access(sat_in_t acc);
        sat_out_t               res;
        int                     a;
        bit                     other_thread;
        bit [COUNT_FIELD_W-1:0] cnt;
        a            = int'(acc.address);
        // an untouched entry counts as a different thread
        other_thread = !touched_tbl[a] || (thread_tbl[a] != acc.thread_id);
        cnt          = touched_tbl[a] ? count_tbl[a] : '0;
        if (touched_tbl[a] && other_thread) begin
            shared_tbl[a] = 1'b1;
        end
        res = '0;
        // every 12-bit index is in range of the 4096-entry bitmap
        if (shared_tbl[a] || other_thread) begin
            res.inst_logged       = 1'b1;
            res.inst_newly_logged = !inst_map[acc.inst_index];
            inst_map[acc.inst_index] = 1'b1;
        end
        touched_tbl[a] = 1'b1;
        thread_tbl[a]  = acc.thread_id;
        if (cnt != '1) begin
            cnt = cnt + 1'b1;
        end
        count_tbl[a] = cnt;
        if (acc.address < low_seen) begin
            low_seen = acc.address;
        end
        if (acc.address > high_seen) begin
            high_seen = acc.address;
        end
        res.access_count    = cnt;
        res.is_shared       = shared_tbl[a];
        res.lowest_address  = low_seen;
        res.highest_address = high_seen;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic queue_access(input logic [ADDR_FIELD_W-1:0] a,
                                input logic [THREAD_FIELD_W-1:0] t,
                                input logic [INST_FIELD_W-1:0] i);
        sat_in_t acc;
        acc.address    = a;
        acc.thread_id  = t;
        acc.inst_index = i;
        accesses_pending.insert(accesses_pending.size(), acc);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (idle_left > 0) begin
                idle_left--;
                s_valid <= 1'b0;
            end else if (accesses_pending.size() == 0) begin
                s_valid <= 1'b0;
            end else if (accesses_pending.size() > QUIET_ITEMS &&
                         $urandom_range(0, 7) == 0) begin
                idle_left = $urandom_range(0, 7);
                s_valid <= 1'b0;
            end else begin
                s_data  <= accesses_pending.pop_front();
                s_valid <= 1'b1;
            end
        end
    end

    // result-side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (accesses_pending.size() > QUIET_ITEMS && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: predict on each accepted access, check each accepted result
    always @(posedge aclk) begin : monitor
        sat_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                results_due.insert(results_due.size(), track_access(s_data));
                n_accepted++;
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                end else begin
                    want = results_due.pop_front();
                    check_field("access_count", want.access_count, m_data.access_count);
                    check_field("is_shared", 32'(want.is_shared), 32'(m_data.is_shared));
                    check_field("inst_logged", 32'(want.inst_logged),
                                32'(m_data.inst_logged));
                    check_field("inst_newly_logged", 32'(want.inst_newly_logged),
                                32'(m_data.inst_newly_logged));
                    check_field("lowest_address", 32'(want.lowest_address),
                                32'(m_data.lowest_address));
                    check_field("highest_address", 32'(want.highest_address),
                                32'(m_data.highest_address));
                    n_checked++;
                    n_shared += int'(want.is_shared);
                    n_fresh  += int'(want.inst_newly_logged);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still due", $time, results_due.size());
            $display("shared_access_tracker_top_tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [ADDR_FIELD_W-1:0]   hot_addr   [24];
        logic [THREAD_FIELD_W-1:0] hot_thread [4];
        logic [INST_FIELD_W-1:0]   hot_inst   [16];
        sat_in_t                   prev;
        logic [ADDR_FIELD_W-1:0]   a;
        logic [THREAD_FIELD_W-1:0] t;
        logic [INST_FIELD_W-1:0]   i;

        // first touch, same-thread repeats, thread switch, shared re-access, address extremes
        queue_access(16'h1234, 8'h05, 12'h007);
        queue_access(16'h1234, 8'h05, 12'h007);
        queue_access(16'h1234, 8'h05, 12'h008);
        queue_access(16'h1234, 8'h09, 12'h007);
        queue_access(16'h1234, 8'h09, 12'h009);
        queue_access(16'h0800, 8'h00, 12'h000);
        queue_access(16'h0800, 8'hFF, 12'hFFF);
        queue_access(16'hF000, 8'hFF, 12'hFFF);
        queue_access(16'h0001, 8'h80, 12'h800);
        queue_access(16'hFFFE, 8'h01, 12'h001);
        queue_access(16'h0000, 8'h00, 12'h000);
        queue_access(16'hFFFF, 8'hFF, 12'hFFF);
        queue_access(16'hFFFF, 8'hFF, 12'hFFF);
        queue_access(16'h0000, 8'hAA, 12'h555);
        queue_access(16'h0000, 8'h55, 12'hAAA);
        queue_access(16'h5555, 8'h55, 12'h555);
        queue_access(16'hAAAA, 8'hAA, 12'hAAA);
        queue_access(16'hAAAA, 8'hAA, 12'hAAA);

        prev = '0;
        for (int n = 0; n < N_RANDOM; n++) begin
            // refresh the hot sets now and then so more entries go shared
            if (n % 200 == 0) begin
                foreach (hot_addr[k]) hot_addr[k] = ADDR_FIELD_W'($urandom);
                foreach (hot_thread[k]) hot_thread[k] = THREAD_FIELD_W'($urandom);
                foreach (hot_inst[k]) hot_inst[k] = INST_FIELD_W'($urandom);
            end
            if ($urandom_range(0, 9) < 3 && n > 0) begin
                a = prev.address;
                t = prev.thread_id;
            end else begin
                a = ($urandom_range(0, 9) < 8) ? hot_addr[$urandom_range(0, 23)]
                                               : ADDR_FIELD_W'($urandom);
                t = ($urandom_range(0, 9) < 7) ? hot_thread[$urandom_range(0, 3)]
                                               : THREAD_FIELD_W'($urandom);
            end
            i = ($urandom_range(0, 1) == 0) ? hot_inst[$urandom_range(0, 15)]
                                            : INST_FIELD_W'($urandom);
            queue_access(a, t, i);
            prev.address   = a;
            prev.thread_id = t;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (accesses_pending.size() != 0 || s_valid) @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("checked %0d of %0d accesses in %0d cycles", n_checked, n_accepted, cycles);
        $display("results on shared entries: %0d, fresh instruction marks: %0d",
                 n_shared, n_fresh);
        if (errors == 0) begin
            $display("shared_access_tracker_top_tb: PASS");
        end else begin
            $display("shared_access_tracker_top_tb: FAIL");
        end
        $finish;
    end

endmodule
